@@ rtl/bgpe_pkg.sv @@
// package: sizes, command codes, register indexes and shared types of the parity encoder
`default_nettype none

package bgpe_pkg;

    localparam int NUM_BATCHES    = 16;
    localparam int MAX_PACKET     = 128;
    localparam int DATA_PACKETS   = 6;
    localparam int PARITY_PACKETS = 3;

    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int BATCH_W    = 4;
    localparam int POS_W      = 7;
    localparam int DIDX_W     = 3;
    localparam int PIDX_W     = 2;
    localparam int ROW_W      = PARITY_PACKETS * BYTE_W;
    localparam int ADDR_W     = BATCH_W + POS_W;
    localparam int STORE_DEPTH = NUM_BATCHES * MAX_PACKET;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DATA_PACKETS * BYTE_W;

    localparam logic [BYTE_W-1:0] GF_POLY_RESET = 8'd29;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GF_POLY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW0 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW1 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ROW2 = 2'd3;

    typedef logic [DATA_PACKETS-1:0][BYTE_W-1:0]   bgpe_wrow_t;
    typedef bgpe_wrow_t [PARITY_PACKETS-1:0]       bgpe_weights_t;
    typedef logic [PARITY_PACKETS-1:0][BYTE_W-1:0] bgpe_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_FETCH,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_WRITE,
        ST_RESP
    } bgpe_state_t;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
    } bgpe_mul_req_t;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] product;
    } bgpe_mul_rsp_t;

endpackage

`default_nettype wire

@@ rtl/bgpe_if.sv @@
// interfaces: command word channel and result word channel
`default_nettype none

interface bgpe_in_if;
    logic                           valid;
    logic                           ready;
    logic [bgpe_pkg::CMD_W-1:0]     cmd;
    logic [bgpe_pkg::BATCH_W-1:0]   batch;
    logic [bgpe_pkg::POS_W-1:0]     batch_size;
    logic [bgpe_pkg::DIDX_W-1:0]    data_index;
    logic [bgpe_pkg::PIDX_W-1:0]    parity_index;
    logic [bgpe_pkg::POS_W-1:0]     byte_pos;
    logic [bgpe_pkg::BYTE_W-1:0]    data_byte;

    modport source (
        output valid, cmd, batch, batch_size, data_index, parity_index, byte_pos, data_byte,
        input  ready
    );
    modport sink (
        input  valid, cmd, batch, batch_size, data_index, parity_index, byte_pos, data_byte,
        output ready
    );
endinterface

interface bgpe_out_if;
    logic                        valid;
    logic                        ready;
    logic [bgpe_pkg::BYTE_W-1:0] parity_byte;
    logic                        status;

    modport source (
        output valid, parity_byte, status,
        input  ready
    );
    modport sink (
        input  valid, parity_byte, status,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/bgpe_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module bgpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bgpe_gf_mul.sv @@
// iterative gf(2^8) multiplier, one bit of the multiplier per cycle
`default_nettype none

module bgpe_gf_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [bgpe_pkg::BYTE_W-1:0] gf_poly,
    input  wire bgpe_pkg::bgpe_mul_req_t     req,
    output bgpe_pkg::bgpe_mul_rsp_t          rsp
);
    import bgpe_pkg::*;

    localparam int CNT_W = $clog2(BYTE_W);

    logic [BYTE_W-1:0] x_reg, x_next;
    logic [BYTE_W-1:0] y_reg;
    logic [BYTE_W-1:0] acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // multiply the running multiplicand by x, reduced
    always_comb
    begin
        if (x_reg[BYTE_W-1])
        begin
            x_next = {x_reg[BYTE_W-2:0], 1'b0} ^ gf_poly;
        end
        else
        begin
            x_next = {x_reg[BYTE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BYTE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.a;
            y_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= {1'b0, y_reg[BYTE_W-1:1]};
            acc_reg <= acc_reg ^ (y_reg[0] ? x_reg : '0);
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

@@ rtl/bgpe_seq.sv @@
// command sequencer: batch sizes, clear walk, read-modify-write of parity words
`default_nettype none

module bgpe_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bgpe_in_if.sink                            in_ch,
    bgpe_out_if.source                         out_ch,
    input  wire bgpe_pkg::bgpe_weights_t       weights,
    output bgpe_pkg::bgpe_mul_req_t            mul_req,
    input  wire bgpe_pkg::bgpe_mul_rsp_t       mul_rsp,
    output logic                               ram_we,
    output logic                               ram_re,
    output logic [bgpe_pkg::ADDR_W-1:0]        ram_addr,
    output bgpe_pkg::bgpe_word_t               ram_wdata,
    input  wire bgpe_pkg::bgpe_word_t          ram_rdata
);
    import bgpe_pkg::*;

    bgpe_state_t state_reg, state_next;

    // latched command word
    logic [CMD_W-1:0]   cmd_reg;
    logic [BATCH_W-1:0] batch_reg;
    logic [POS_W-1:0]   size_reg;
    logic [DIDX_W-1:0]  didx_reg;
    logic [PIDX_W-1:0]  pidx_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [BYTE_W-1:0]  dbyte_reg;

    logic [POS_W-1:0]   sizes_reg [NUM_BATCHES];
    logic [POS_W-1:0]   clr_cnt_reg;
    logic [PIDX_W-1:0]  row_reg;
    bgpe_word_t         word_reg;

    logic [BYTE_W-1:0]  res_parity_reg;
    logic               res_status_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_parity_reg;
    logic               out_status_reg;

    logic [POS_W-1:0]   cur_size;
    logic               batch_ok, pos_ok;
    logic               start_ok, enc_ok, read_ok;
    logic               clr_last, row_last, out_free;

    assign cur_size = sizes_reg[batch_reg];
    assign batch_ok = {1'b0, batch_reg} < (BATCH_W + 1)'(NUM_BATCHES);
    assign pos_ok   = pos_reg < cur_size;
    assign start_ok = (cmd_reg == CMD_START) && batch_ok;
    assign enc_ok   = (cmd_reg == CMD_ENCODE) && batch_ok && pos_ok
                      && ({1'b0, didx_reg} < (DIDX_W + 1)'(DATA_PACKETS));
    assign read_ok  = (cmd_reg == CMD_READ) && batch_ok && pos_ok
                      && ({1'b0, pidx_reg} < (PIDX_W + 1)'(PARITY_PACKETS));
    assign clr_last = ({1'b0, clr_cnt_reg} + 1'b1) == {1'b0, size_reg};
    assign row_last = row_reg == PIDX_W'(PARITY_PACKETS - 1);
    assign out_free = !out_valid_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (start_ok && (size_reg != '0))
                begin
                    state_next = ST_CLEAR;
                end
                else if (enc_ok || read_ok)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FETCH:
            begin
                if (cmd_reg == CMD_ENCODE)
                begin
                    state_next = ST_MUL_LOAD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MUL_LOAD:
            begin
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                if (mul_rsp.done)
                begin
                    state_next = row_last ? ST_WRITE : ST_MUL_LOAD;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_addr      = {batch_reg, pos_reg};
        ram_wdata     = word_reg;
        mul_req.start = 1'b0;
        mul_req.a     = weights[row_reg][didx_reg];
        mul_req.b     = dbyte_reg;
        in_ch.ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_DECODE:
            begin
                ram_re = enc_ok || read_ok;
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = {batch_reg, clr_cnt_reg};
                ram_wdata = '0;
            end
            ST_MUL_LOAD:
            begin
                mul_req.start = 1'b1;
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg   <= in_ch.cmd;
                batch_reg <= in_ch.batch;
                size_reg  <= in_ch.batch_size;
                didx_reg  <= in_ch.data_index;
                pidx_reg  <= in_ch.parity_index;
                pos_reg   <= in_ch.byte_pos;
                dbyte_reg <= in_ch.data_byte;
            end
            ST_DECODE:
            begin
                // a 7-bit size never exceeds the packet length, no saturation needed
                if (start_ok)
                begin
                    sizes_reg[batch_reg] <= size_reg;
                end
                clr_cnt_reg    <= '0;
                res_parity_reg <= '0;
                res_status_reg <= !(start_ok || enc_ok || read_ok);
            end
            ST_CLEAR:
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            ST_FETCH:
            begin
                word_reg <= ram_rdata;
                row_reg  <= '0;
                if (cmd_reg == CMD_READ)
                begin
                    res_parity_reg <= ram_rdata[pidx_reg];
                end
            end
            ST_MUL_RUN:
            begin
                if (mul_rsp.done)
                begin
                    word_reg[row_reg] <= word_reg[row_reg] ^ mul_rsp.product;
                    row_reg           <= row_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_parity_reg <= res_parity_reg;
                    out_status_reg <= res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.parity_byte = out_parity_reg;
    assign out_ch.status      = out_status_reg;

endmodule

`default_nettype wire

@@ rtl/batched_gf256_parity_encoder_top.sv @@
// top level: gf(2^8) erasure parity encoder for several batches
//
// the block keeps three parity rows per batch, 16 batches of up to 127 byte
// positions, in one 2048 x 24 ram. the block takes no new command word until
// the current one is finished; its result waits in an output register so the
// next command word can be accepted while the result is still pending.
// a start word clears the batch one ram word per cycle. an encode word does
// one ram read, then three products through the one shared multiplier, which
// handles one multiplier bit per cycle, then one ram write. a read word does
// one ram read. the parity store is not cleared at reset; a batch must be
// started before use. configuration must be written through cfg_we /
// cfg_index / cfg_data only while idle; the block itself does not enforce this.
`default_nettype none

module batched_gf256_parity_encoder_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bgpe_in_if.sink                               in_ch,
    bgpe_out_if.source                            out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [bgpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bgpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bgpe_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] gf_poly_reg;
    bgpe_weights_t     weights_reg;

    // shared multiplier handshake
    bgpe_mul_req_t     mul_req;
    bgpe_mul_rsp_t     mul_rsp;

    // parity store port
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    bgpe_word_t        ram_wdata;
    bgpe_word_t        ram_rdata;

    // config writes, one register per index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gf_poly_reg <= GF_POLY_RESET;
            weights_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GF_POLY:     gf_poly_reg    <= cfg_data[BYTE_W-1:0];
                CFG_WEIGHT_ROW0: weights_reg[0] <= cfg_data;
                CFG_WEIGHT_ROW1: weights_reg[1] <= cfg_data;
                CFG_WEIGHT_ROW2: weights_reg[2] <= cfg_data;
                default:         gf_poly_reg    <= gf_poly_reg;
            endcase
        end
    end

    // command sequencer
    bgpe_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .weights   (weights_reg),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    // one multiplier shared by all three parity rows
    bgpe_gf_mul u_gf_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .gf_poly (gf_poly_reg),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // parity store, address is {batch, byte position}
    bgpe_ram #(
        .WIDTH (ROW_W),
        .DEPTH (STORE_DEPTH)
    ) u_parity_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/bgpe_checker.sv @@
// port checker for the parity encoder and its bind
`default_nettype none

module bgpe_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [bgpe_pkg::BYTE_W-1:0] out_parity_byte,
    input wire logic                        out_status
);
    import bgpe_pkg::*;

    // result word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_parity_byte) && $stable(out_status))
    else $error("result word changed while stalled");

    // every command word keeps the block busy past the accepting cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("command word accepted in consecutive cycles");

    // an ignored word never carries a parity byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status |-> out_parity_byte == '0)
    else $error("nonzero parity byte on ignored word");

endmodule

bind batched_gf256_parity_encoder_top bgpe_checker u_bgpe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_parity_byte (out_ch.parity_byte),
    .out_status      (out_ch.status)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for the batched gf(2^8) erasure parity encoder
`timescale 1ns / 1ps

module testbench;
    import bgpe_pkg::*;

    // command code with no meaning, the block must reject it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // run ends here no matter what, far above the slowest correct run
    localparam int CYCLE_LIMIT = 2_000_000;
    // cycles the receiver holds off in the back-pressure test
    localparam int HOLD_CYCLES = 600;
    // quiet time at the end, longer than a full-size batch start
    localparam int TAIL_CYCLES = 160;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BATCH_W-1:0] batch;
        logic [POS_W-1:0]   batch_size;
        logic [DIDX_W-1:0]  data_index;
        logic [PIDX_W-1:0]  parity_index;
        logic [POS_W-1:0]   byte_pos;
        logic [BYTE_W-1:0]  data_byte;
    } cmd_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] parity_byte;
        logic              status;
    } result_word_t;

    // stall patterns of the result side
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bgpe_in_if  in_ch ();
    bgpe_out_if out_ch ();

    batched_gf256_parity_encoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // own copy of the block's state and configuration
    bgpe_word_t    parity_mem [NUM_BATCHES][MAX_PACKET];
    int            batch_len  [NUM_BATCHES];
    logic [7:0]    poly_q;
    bgpe_weights_t weight_q;

    // results still owed by the block, oldest first
    result_word_t parity_result_q [$];

    int fail_count;
    int ok_words;      // accepted words that the block does not reject
    int burst_left;    // words left in the current sender burst
    int cycle_count;
    logic hold_req;    // asks the receiver for one long hold-off

    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_hold_left;
    int       rx_tick;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ring product mod x^8 + poly, msb first
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] poly);
        logic [7:0] acc;
        acc = '0;
        for (int i = 7; i >= 0; i--)
        begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? poly : 8'h00);
            if (b[i])
                acc ^= a;
        end
        return acc;
    endfunction

    // expected result of one accepted word, updates the model state
    function automatic result_word_t predict_result(input cmd_word_t w);
        result_word_t r;
        int b;
        int pos;
        r.parity_byte = '0;
        r.status      = 1'b1;
        b   = int'(w.batch);
        pos = int'(w.byte_pos);
        case (w.cmd)
            CMD_START:
            begin
                // size is at most 127, so no saturation is ever needed
                batch_len[b] = int'(w.batch_size);
                for (int n = 0; n < int'(w.batch_size); n++)
                    parity_mem[b][n] = '0;
                r.status = 1'b0;
            end
            CMD_ENCODE:
            begin
                if (pos < batch_len[b] && int'(w.data_index) < DATA_PACKETS)
                begin
                    for (int row = 0; row < PARITY_PACKETS; row++)
                        parity_mem[b][pos][row] ^=
                            gf_product(weight_q[row][w.data_index], w.data_byte, poly_q);
                    r.status = 1'b0;
                end
            end
            CMD_READ:
            begin
                if (pos < batch_len[b] && int'(w.parity_index) < PARITY_PACKETS)
                begin
                    r.parity_byte = parity_mem[b][pos][w.parity_index];
                    r.status      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [47:0] rnd48();
        return 48'({$urandom, $urandom});
    endfunction

    // word with every field random except the command
    function automatic cmd_word_t random_word(input logic [CMD_W-1:0] cmd);
        cmd_word_t w;
        w.cmd          = cmd;
        w.batch        = BATCH_W'($urandom);
        w.batch_size   = POS_W'($urandom);
        w.data_index   = DIDX_W'($urandom);
        w.parity_index = PIDX_W'($urandom);
        w.byte_pos     = POS_W'($urandom);
        w.data_byte    = BYTE_W'($urandom);
        return w;
    endfunction

    // offer one word, bursts with random gaps between them
    task automatic send_word(input cmd_word_t w);
        int gap;
        result_word_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long burst with no idle cycle at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= w.cmd;
        in_ch.batch        <= w.batch;
        in_ch.batch_size   <= w.batch_size;
        in_ch.data_index   <= w.data_index;
        in_ch.parity_index <= w.parity_index;
        in_ch.byte_pos     <= w.byte_pos;
        in_ch.data_byte    <= w.data_byte;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        r = predict_result(w);
        parity_result_q.push_back(r);
        if (!r.status)
            ok_words++;
    endtask

    task automatic open_batch(input int b, input int n);
        cmd_word_t w;
        w = random_word(CMD_START);
        w.batch      = BATCH_W'(b);
        w.batch_size = POS_W'(n);
        send_word(w);
    endtask

    task automatic encode_byte(input int b, input int didx, input int pos,
                               input logic [7:0] dbyte);
        cmd_word_t w;
        w = random_word(CMD_ENCODE);
        w.batch      = BATCH_W'(b);
        w.data_index = DIDX_W'(didx);
        w.byte_pos   = POS_W'(pos);
        w.data_byte  = dbyte;
        send_word(w);
    endtask

    task automatic read_parity(input int b, input int pidx, input int pos);
        cmd_word_t w;
        w = random_word(CMD_READ);
        w.batch        = BATCH_W'(b);
        w.parity_index = PIDX_W'(pidx);
        w.byte_pos     = POS_W'(pos);
        send_word(w);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (parity_result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GF_POLY:     poly_q      = data[7:0];
            CFG_WEIGHT_ROW0: weight_q[0] = data;
            CFG_WEIGHT_ROW1: weight_q[1] = data;
            CFG_WEIGHT_ROW2: weight_q[2] = data;
            default:         ;
        endcase
        @(posedge clk);
    endtask

    // new field polynomial and weights, only once the block is idle
    task automatic configure(input logic [7:0] poly, input logic [47:0] w0,
                             input logic [47:0] w1, input logic [47:0] w2);
        logic [47:0] poly_data;
        wait_drained();
        // upper bits of the polynomial register carry junk on purpose
        poly_data       = rnd48();
        poly_data[7:0]  = poly;
        write_reg(CFG_GF_POLY, poly_data);
        write_reg(CFG_WEIGHT_ROW0, w0);
        write_reg(CFG_WEIGHT_ROW1, w1);
        write_reg(CFG_WEIGHT_ROW2, w2);
    endtask

    // every batch gets a size before anything touches it
    task automatic test_batch_setup();
        for (int b = 0; b < NUM_BATCHES; b++)
            open_batch(b, MAX_PACKET - 1);
    endtask

    // reset weights are zero, so every parity byte stays zero
    task automatic test_reset_weights();
        encode_byte(0, 0, 0, 8'hFF);
        encode_byte(0, 5, 126, 8'hA5);
        read_parity(0, 0, 0);
        read_parity(0, 1, 0);
        read_parity(0, 2, 126);
    endtask

    task automatic test_directed_cases();
        cmd_word_t w;
        configure(GF_POLY_RESET, rnd48(), rnd48(), rnd48());
        // empty batch: start is fine, every access is out of range
        open_batch(3, 0);
        encode_byte(3, 0, 0, 8'h5A);
        read_parity(3, 0, 0);
        // full-size batch, first and last positions, extreme bytes
        open_batch(5, MAX_PACKET - 1);
        encode_byte(5, 0, 0, 8'hFF);
        encode_byte(5, 5, 126, 8'h80);
        encode_byte(5, 2, 0, 8'h00);
        encode_byte(5, 1, 127, 8'h3C);
        // data packet numbers past the last one
        encode_byte(5, 6, 1, 8'h11);
        encode_byte(5, 7, 1, 8'h22);
        read_parity(5, 0, 0);
        read_parity(5, 1, 0);
        read_parity(5, 2, 0);
        read_parity(5, 2, 126);
        // parity row past the last one, position past the size
        read_parity(5, 3, 0);
        read_parity(5, 0, 127);
        // unused command code
        w = random_word(CMD_UNUSED);
        w.batch = BATCH_W'(5);
        send_word(w);
        // one-byte batch
        open_batch(15, 1);
        encode_byte(15, 3, 0, 8'h01);
        read_parity(15, 1, 0);
        read_parity(15, 1, 1);
        // restart clears what was accumulated
        open_batch(5, MAX_PACKET - 1);
        read_parity(5, 0, 0);
    endtask

    // result side stalls for a long stretch while words keep coming
    task automatic test_backpressure();
        open_batch(7, 32);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            encode_byte(7, $urandom_range(0, DATA_PACKETS - 1), $urandom_range(0, 31),
                        8'($urandom));
        for (int i = 0; i < 8; i++)
            read_parity(7, $urandom_range(0, PARITY_PACKETS - 1), $urandom_range(0, 31));
        wait_drained();
    endtask

    // mostly packet streams into one batch, some noise in between
    task automatic run_traffic(input int n_ok);
        int target;
        int b;
        int n;
        int k;
        target = ok_words + n_ok;
        while (ok_words < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                b = $urandom_range(0, NUM_BATCHES - 1);
                case ($urandom_range(0, 15))
                    0:       n = 0;
                    1:       n = $urandom_range(64, MAX_PACKET - 1);
                    default: n = $urandom_range(1, 16);
                endcase
                open_batch(b, n);
                if (n > 0)
                begin
                    k = $urandom_range(1, 24);
                    for (int i = 0; i < k; i++)
                    begin
                        encode_byte(b, $urandom_range(0, DATA_PACKETS - 1),
                                    $urandom_range(0, n - 1), 8'($urandom));
                        if ($urandom_range(0, 3) == 0)
                            read_parity(b, $urandom_range(0, PARITY_PACKETS - 1),
                                        $urandom_range(0, n - 1));
                    end
                    k = $urandom_range(1, 8);
                    for (int i = 0; i < k; i++)
                        read_parity(b, $urandom_range(0, PARITY_PACKETS - 1),
                                    $urandom_range(0, n - 1));
                end
            end
            else
            begin
                // fully random fields, including broken indexes and positions
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    case ($urandom_range(0, 9))
                        0:          send_word(random_word(CMD_START));
                        1, 2, 3, 4: send_word(random_word(CMD_ENCODE));
                        5, 6, 7, 8: send_word(random_word(CMD_READ));
                        default:    send_word(random_word(CMD_UNUSED));
                    endcase
                end
            end
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
    endtask

    task automatic test_random_traffic();
        configure(GF_POLY_RESET, rnd48(), rnd48(), rnd48());
        run_traffic(320);
        configure(8'h00, '1, '1, '1);
        run_traffic(260);
        configure(8'hFF, rnd48(), rnd48(), rnd48());
        run_traffic(320);
        configure(8'($urandom), '0, '1, rnd48());
        run_traffic(260);
        configure(8'h2B, rnd48(), rnd48(), rnd48());
        run_traffic(320);
    endtask

    // result side: checks each accepted word and drives ready
    initial
    begin : result_side
        result_word_t want;
        logic rdy;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (parity_result_q.size() == 0)
                begin
                    $error("result word with nothing expected: parity_byte %0h status %0b",
                           out_ch.parity_byte, out_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = parity_result_q.pop_front();
                    if (out_ch.parity_byte !== want.parity_byte)
                    begin
                        $error("parity_byte mismatch: expected %0h actual %0h",
                               want.parity_byte, out_ch.parity_byte);
                        fail_count++;
                    end
                    if (out_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0b actual %0b",
                               want.status, out_ch.status);
                        fail_count++;
                    end
                end
            end
            // a requested hold-off wins over the normal pattern
            if (hold_req)
            begin
                hold_req     = 1'b0;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = rx_mode_t'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = ((rx_tick % 3) != 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // stimulus: reset, then the tests in turn, then the final verdict
    initial
    begin
        // every input known from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = '0;
        in_ch.batch        = '0;
        in_ch.batch_size   = '0;
        in_ch.data_index   = '0;
        in_ch.parity_index = '0;
        in_ch.byte_pos     = '0;
        in_ch.data_byte    = '0;
        // model state starts at the register reset values
        poly_q       = GF_POLY_RESET;
        weight_q     = '0;
        fail_count   = 0;
        ok_words     = 0;
        burst_left   = 0;
        cycle_count  = 0;
        hold_req     = 1'b0;
        rx_mode      = RX_OPEN;
        rx_mode_left = 0;
        rx_hold_left = 0;
        rx_tick      = 0;
        for (int b = 0; b < NUM_BATCHES; b++)
            batch_len[b] = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_batch_setup();
        test_reset_weights();
        test_directed_cases();
        test_backpressure();
        test_random_traffic();

        // everything owed has to arrive, then nothing more may show up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && parity_result_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
